// ===== sv/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define MTQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define MTQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/mtq_pkg.sv =====
// types, constants and helpers for the multi timeout queue
package mtq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int TIME_W      = 32;
  localparam int DUR_W       = 31;
  localparam int CNT_W       = 5;

  localparam logic [DUR_W-1:0] DUR_RESET = 31'd1000;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_ADD     = 2'd1,
    OP_ADD_DLY = 2'd2,
    OP_CANCEL  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_CHECK
  } state_e;

  typedef struct packed {
    op_e              opcode;
    logic [DUR_W-1:0] delay;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [CNT_W-1:0]  pending_count;
    logic [CNT_W-1:0]  newly_expired;
    logic [TIME_W-1:0] expired_total;
  } rsp_t;

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] nxt;
    if (idx == IDX_W'(QUEUE_DEPTH - 1)) begin
      nxt = '0;
    end else begin
      nxt = idx + 1'b1;
    end
    return nxt;
  endfunction

endpackage

// ===== sv/multi_timeout_queue.sv =====
// multi timeout queue: ring of alarm start stamps with one shared duration
//
// requests enter on req_i when start is high and busy is low; opcodes are
// tick (advance time), add, delayed add and cancel oldest. the duration
// register is written over cfg_valid_i/cfg_ready_o with cfg_data_i, and is
// taken only while no request is in flight.
// every request gives one response on rsp_o, marked by rsp_valid_o for a
// single cycle; the receiver cannot stall, so nothing is held back.
// a request goes from acceptance through an update of the ring, a read of
// the head stamp from the stamp ram and a compare for each head looked at
// (the ram gives one registered read a cycle) to the registered response;
// the compares are left out when no alarm is left pending, and go on while
// the head looked at has expired and another alarm is pending.
// busy falls in the cycle the response shows, so the next request can be
// taken alongside it.
// stamps are written in the update cycle and read no earlier than the next,
// so the ram never sees a read and a write of the same entry together.
// reset empties the ring, clears time and counters and sets the duration to
// 1000; the stamp ram is not cleared, no entry is read before it is written.
module multi_timeout_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  mtq_pkg::req_t               req_i,
  output logic                        rsp_valid_o,
  output mtq_pkg::rsp_t               rsp_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [mtq_pkg::DUR_W-1:0]   cfg_data_i
);

  mtq_pkg::state_e                  state_q, state_d;
  mtq_pkg::op_e                     op_q, op_d;
  logic [mtq_pkg::TIME_W-1:0]       cand_q, cand_d;
  logic [mtq_pkg::TIME_W-1:0]       time_q, time_d;
  logic [mtq_pkg::TIME_W-1:0]       last_q, last_d;
  logic [mtq_pkg::TIME_W-1:0]       total_q, total_d;
  logic [mtq_pkg::IDX_W-1:0]        head_q, head_d;
  logic [mtq_pkg::IDX_W-1:0]        tail_q, tail_d;
  logic [mtq_pkg::OCC_W-1:0]        occ_q, occ_d;
  logic [mtq_pkg::OCC_W-1:0]        popped_q, popped_d;
  logic [mtq_pkg::DUR_W-1:0]        dur_q, dur_d;
  mtq_pkg::status_e                 status_q, status_d;
  mtq_pkg::rsp_t                    rsp_q, rsp_d;
  logic                             rsp_valid_q, rsp_valid_d;

  logic                             accept;
  logic                             full;
  logic [mtq_pkg::TIME_W-1:0]       ahead;
  logic                             use_cand;
  logic [mtq_pkg::TIME_W-1:0]       stamp;
  logic [mtq_pkg::TIME_W-1:0]       elapsed;
  logic                             expired;
  logic                             finish;

  logic                             ram_we;
  logic                             ram_re;
  logic [mtq_pkg::IDX_W-1:0]        ram_raddr;
  logic [mtq_pkg::TIME_W-1:0]       ram_rdata;

  mtq_ram #(
    .WIDTH (mtq_pkg::TIME_W),
    .DEPTH (mtq_pkg::QUEUE_DEPTH)
  ) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (stamp),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign accept = start && !busy;
  assign full   = (occ_q == mtq_pkg::OCC_W'(mtq_pkg::QUEUE_DEPTH));

  // delayed add takes the candidate only when it lies strictly ahead of now
  assign ahead    = cand_q - time_q;
  assign use_cand = (op_q == mtq_pkg::OP_ADD_DLY) && (occ_q != '0) &&
                    (ahead != '0) && !ahead[mtq_pkg::TIME_W-1];
  assign stamp    = use_cand ? cand_q : time_q;

  // negative elapsed time means a future stamp, which never expires
  assign elapsed = time_q - ram_rdata;
  assign expired = !elapsed[mtq_pkg::TIME_W-1] &&
                   (elapsed[mtq_pkg::TIME_W-2:0] > dur_q);

  always_comb begin
    finish = 1'b0;
    case (state_q)
      mtq_pkg::S_READ:  finish = (occ_q == '0);
      mtq_pkg::S_CHECK: finish = !expired || (occ_q == mtq_pkg::OCC_W'(1));
      default:          finish = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mtq_pkg::S_IDLE:  if (accept) state_d = mtq_pkg::S_EXEC;
      mtq_pkg::S_EXEC:  state_d = mtq_pkg::S_READ;
      mtq_pkg::S_READ:  state_d = finish ? mtq_pkg::S_IDLE : mtq_pkg::S_CHECK;
      mtq_pkg::S_CHECK: if (finish) state_d = mtq_pkg::S_IDLE;
      default:          state_d = mtq_pkg::S_IDLE;
    endcase
  end

  // handshake and ram controls
  always_comb begin
    busy        = 1'b1;
    cfg_ready_o = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = head_q;
    case (state_q)
      mtq_pkg::S_IDLE: begin
        busy        = 1'b0;
        cfg_ready_o = 1'b1;
      end
      mtq_pkg::S_EXEC: begin
        ram_we = ((op_q == mtq_pkg::OP_ADD) || (op_q == mtq_pkg::OP_ADD_DLY)) && !full;
      end
      mtq_pkg::S_READ: begin
        ram_re = (occ_q != '0);
      end
      mtq_pkg::S_CHECK: begin
        // fetch the next head while popping this one
        ram_re    = !finish;
        ram_raddr = mtq_pkg::next_slot(head_q);
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // datapath
  always_comb begin
    op_d        = op_q;
    cand_d      = cand_q;
    time_d      = time_q;
    last_d      = last_q;
    total_d     = total_q;
    head_d      = head_q;
    tail_d      = tail_q;
    occ_d       = occ_q;
    popped_d    = popped_q;
    dur_d       = dur_q;
    status_d    = status_q;

    if (cfg_valid_i && cfg_ready_o) begin
      dur_d = cfg_data_i;
    end

    case (state_q)
      mtq_pkg::S_IDLE: begin
        if (accept) begin
          op_d     = req_i.opcode;
          cand_d   = last_q + {1'b0, req_i.delay};
          status_d = mtq_pkg::ST_OK;
          popped_d = '0;
        end
      end
      mtq_pkg::S_EXEC: begin
        case (op_q)
          mtq_pkg::OP_TICK: begin
            time_d = time_q + 1'b1;
          end
          mtq_pkg::OP_ADD, mtq_pkg::OP_ADD_DLY: begin
            if (full) begin
              status_d = mtq_pkg::ST_FULL;
            end else begin
              tail_d = mtq_pkg::next_slot(tail_q);
              occ_d  = occ_q + 1'b1;
              last_d = stamp;
            end
          end
          mtq_pkg::OP_CANCEL: begin
            if (occ_q == '0) begin
              status_d = mtq_pkg::ST_EMPTY;
            end else begin
              head_d = mtq_pkg::next_slot(head_q);
              occ_d  = occ_q - 1'b1;
            end
          end
          default: begin
            status_d = status_q;
          end
        endcase
      end
      mtq_pkg::S_CHECK: begin
        if (expired) begin
          head_d   = mtq_pkg::next_slot(head_q);
          occ_d    = occ_q - 1'b1;
          popped_d = popped_q + 1'b1;
          total_d  = total_q + 1'b1;
        end
      end
      default: begin
        status_d = status_q;
      end
    endcase

    rsp_valid_d           = finish;
    rsp_d                 = rsp_q;
    if (finish) begin
      rsp_d.status        = status_q;
      rsp_d.pending_count = mtq_pkg::CNT_W'(occ_d);
      rsp_d.newly_expired = mtq_pkg::CNT_W'(popped_d);
      rsp_d.expired_total = total_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mtq_pkg::S_IDLE;
      time_q      <= '0;
      last_q      <= '0;
      total_q     <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      occ_q       <= '0;
      dur_q       <= mtq_pkg::DUR_RESET;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      time_q      <= time_d;
      last_q      <= last_d;
      total_q     <= total_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      occ_q       <= occ_d;
      dur_q       <= dur_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    cand_q   <= cand_d;
    popped_q <= popped_d;
    status_q <= status_d;
    rsp_q    <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

// ===== sv/mtq_ram.sv =====
// generic single-port-write, registered-read ram
module mtq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/mtq_checker.sv =====
// port-level checks for the multi timeout queue, bound to the top level
`include "assert_macros.svh"

module mtq_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start,
  input logic                      busy,
  input mtq_pkg::req_t             req_i,
  input logic                      rsp_valid_o,
  input mtq_pkg::rsp_t             rsp_o,
  input logic                      cfg_valid_i,
  input logic                      cfg_ready_o,
  input logic [mtq_pkg::DUR_W-1:0] cfg_data_i
);

  logic req_unused;
  logic cfg_unused;

  assign req_unused = ^req_i;
  assign cfg_unused = cfg_valid_i ^ (^cfg_data_i);

  // an accepted request keeps the block busy while it works
  `MTQ_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  // a response only ends a busy stretch
  `MTQ_ASSERT_NOW(a_rsp_after_busy, rsp_valid_o, $past(busy) && !busy)
  // one response per request, never two in a row
  `MTQ_ASSERT_NXT(a_rsp_single, rsp_valid_o, !rsp_valid_o)
  // pending alarms never exceed the ring size
  `MTQ_ASSERT_NOW(a_pending_bound, rsp_valid_o,
                  rsp_o.pending_count <= mtq_pkg::CNT_W'(mtq_pkg::QUEUE_DEPTH))
  // duration writes are refused while a request is in flight
  `MTQ_ASSERT_NOW(a_cfg_idle_only, busy, !cfg_ready_o)

endmodule

bind multi_timeout_queue mtq_checker u_mtq_checker (.*);
